FILE: hw/rtl/trapezoid_speed_ramp_assert.svh
// Assertion macros for the ramp RTL; they expand to nothing in synthesis.
`ifndef TRAPEZOID_SPEED_RAMP_ASSERT_SVH
`define TRAPEZOID_SPEED_RAMP_ASSERT_SVH

`ifndef SYNTHESIS
`define TSR_ASSERT_IMP(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("assertion failed");
`define TSR_ASSERT_NXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`else
`define TSR_ASSERT_IMP(label, pre, post)
`define TSR_ASSERT_NXT(label, pre, post)
`endif

`endif

FILE: hw/rtl/tsr_pkg.sv
package tsr_pkg;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_UP   = 2'd1;
	localparam logic [1:0] PH_HOLD = 2'd2;
	localparam logic [1:0] PH_DOWN = 2'd3;

	localparam logic [1:0] REG_STEP  = 2'd0;
	localparam logic [1:0] REG_LIMIT = 2'd1;
	localparam logic [1:0] REG_HOLD  = 2'd2;

	localparam logic        REQ_TICK  = 1'b0;
	localparam logic        REQ_START = 1'b1;

	localparam logic [11:0] STEP_RESET  = 12'd98;
	localparam logic [14:0] LIMIT_RESET = 15'd8192;
	localparam logic [15:0] HOLD_RESET  = 16'd323;

	typedef struct packed {
		logic [11:0] step_inc;
		logic [14:0] speed_limit;
		logic [15:0] hold_ticks;
	} cfg_t;

	typedef struct packed {
		logic signed [15:0] drive;
		logic [1:0]         phase;
		logic [15:0]        hold_cnt;
		logic               reverse;
	} state_t;

	typedef struct packed {
		logic signed [15:0] drive_value;
		logic               running;
		logic [1:0]         phase;
		logic               run_done;
	} result_t;

endpackage

FILE: hw/rtl/tsr_cfg.sv
module tsr_cfg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [1:0]    wr_index,
	input  logic [15:0]   wr_data,
	output tsr_pkg::cfg_t cfg
);
	import tsr_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_inc    <= STEP_RESET;
			cfg_q.speed_limit <= LIMIT_RESET;
			cfg_q.hold_ticks  <= HOLD_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_STEP:  cfg_q.step_inc    <= wr_data[11:0];
				REG_LIMIT: cfg_q.speed_limit <= wr_data[14:0];
				REG_HOLD:  cfg_q.hold_ticks  <= wr_data;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: hw/rtl/tsr_step.sv
module tsr_step (
	input  tsr_pkg::cfg_t    cfg,
	input  tsr_pkg::state_t  cur,
	input  logic             req_type,
	input  logic             direction,
	output tsr_pkg::state_t  nxt,
	output tsr_pkg::result_t res
);
	import tsr_pkg::*;

	logic signed [16:0] drv_x;
	logic signed [16:0] step_x;
	logic signed [16:0] lim_x;
	logic signed [16:0] nlim_x;
	logic signed [16:0] plus_x;
	logic signed [16:0] minus_x;
	logic [16:0]        cnt_x;
	logic               done;

	assign drv_x   = {cur.drive[15], cur.drive};
	assign step_x  = signed'({5'd0, cfg.step_inc});
	assign lim_x   = signed'({2'd0, cfg.speed_limit});
	assign nlim_x  = -lim_x;
	assign plus_x  = drv_x + step_x;
	assign minus_x = drv_x - step_x;
	assign cnt_x   = {1'b0, cur.hold_cnt} + 17'd1;

	always_comb begin
		nxt  = cur;
		done = 1'b0;
		if (req_type == REQ_START) begin
			if (cur.phase == PH_IDLE) begin
				nxt.phase    = PH_UP;
				nxt.reverse  = direction;
				nxt.hold_cnt = '0;
			end
		end else begin
			case (cur.phase)
				PH_UP: begin
					if (!cur.reverse) begin
						if (plus_x >= lim_x) begin
							nxt.drive    = lim_x[15:0];
							nxt.phase    = PH_HOLD;
							nxt.hold_cnt = '0;
						end else begin
							nxt.drive = plus_x[15:0];
						end
					end else begin
						if (minus_x <= nlim_x) begin
							nxt.drive    = nlim_x[15:0];
							nxt.phase    = PH_HOLD;
							nxt.hold_cnt = '0;
						end else begin
							nxt.drive = minus_x[15:0];
						end
					end
				end
				PH_HOLD: begin
					if (cnt_x >= {1'b0, cfg.hold_ticks}) begin
						nxt.phase    = PH_DOWN;
						nxt.hold_cnt = '0;
					end else begin
						nxt.hold_cnt = cnt_x[15:0];
					end
				end
				PH_DOWN: begin
					if ((!cur.reverse && minus_x <= 17'sd0)
							|| (cur.reverse && plus_x >= 17'sd0)) begin
						nxt.drive    = '0;
						nxt.phase    = PH_IDLE;
						nxt.hold_cnt = '0;
						done         = 1'b1;
					end else begin
						nxt.drive = cur.reverse ? plus_x[15:0] : minus_x[15:0];
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign res.drive_value = nxt.drive;
	assign res.running     = (nxt.phase != PH_IDLE);
	assign res.phase       = nxt.phase;
	assign res.run_done    = done;

endmodule

FILE: hw/rtl/trapezoid_speed_ramp.sv
// Trapezoidal speed profile generator for motor tests.
// Request channel (item_valid, item_stall, req_type, direction): a word is
// either a timer tick or a start request carrying the run direction.
// Result channel (res_valid, res_stall, drive_value, running, phase,
// run_done): exactly one result word per request word, in order.
// Configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes
// step size, speed limit and hold length; it is always ready and should
// only be used while no request or result word is in flight.
// A request word is registered on acceptance; from the request register its
// state update and result are computed in one pass and loaded into the
// result register, which offers the result word. While the result channel
// does not stall, one word is taken every cycle; the profile state update,
// a loop closed through the state register, is what sets this rate.
// A stalled result holds its register; the request register keeps accepting
// until it is itself occupied, then item_stall rises.
// Reset clears the profile state to idle with zero drive, empties both
// registers and restores the default step, limit and hold length.
module trapezoid_speed_ramp (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic               req_type,
	input  logic               direction,
	output logic               res_valid,
	input  logic               res_stall,
	output logic signed [15:0] drive_value,
	output logic               running,
	output logic [1:0]         phase,
	output logic               run_done,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data
);
	import tsr_pkg::*;

	`include "trapezoid_speed_ramp_assert.svh"

	cfg_t    cfg;
	state_t  state_q;
	state_t  state_nxt;
	result_t res_nxt;
	result_t res_q;
	logic    valid_s1;
	logic    req_s1;
	logic    dir_s1;
	logic    res_valid_q;
	logic    advance;
	logic    fire_s1;

	assign cfg_ready = 1'b1;

	tsr_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	assign advance    = !res_valid_q || !res_stall;
	assign fire_s1    = valid_s1 && advance;
	assign item_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			req_s1 <= req_type;
			dir_s1 <= direction;
		end
	end

	tsr_step u_step (
		.cfg       (cfg),
		.cur       (state_q),
		.req_type  (req_s1),
		.direction (dir_s1),
		.nxt       (state_nxt),
		.res       (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (fire_s1) begin
				state_q <= state_nxt;
			end
			if (advance) begin
				res_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			res_q <= res_nxt;
		end
	end

	assign res_valid   = res_valid_q;
	assign drive_value = res_q.drive_value;
	assign running     = res_q.running;
	assign phase       = res_q.phase;
	assign run_done    = res_q.run_done;

	`TSR_ASSERT_IMP(a_idle_zero_drive, state_q.phase == PH_IDLE, state_q.drive == 16'sd0)
	`TSR_ASSERT_IMP(a_done_idle, res_valid_q && res_q.run_done,
		res_q.phase == PH_IDLE && res_q.drive_value == 16'sd0 && !res_q.running)
	`TSR_ASSERT_IMP(a_running_phase, res_valid_q, res_q.running == (res_q.phase != PH_IDLE))
	`TSR_ASSERT_NXT(a_fire_result, fire_s1, res_valid_q)

endmodule
